// ===== hw/rtl/owdm_pkg.sv =====
// Types, widths and constants of the omni wheel drive mixer.
// Stand-alone package; the top level takes it by wildcard import.
package owdm_pkg;

    // field widths
    localparam int DATA_W   = 16;
    localparam int ANG_W    = 18;     // working angle, 12 fraction bits
    localparam int ANG_A_W  = 13;     // in-quadrant angle, 0 .. pi/2
    localparam int XY_W     = 27;     // CORDIC x and y, 24 fraction bits
    localparam int Z_W      = 20;     // CORDIC residual angle, 16 fraction bits
    localparam int ITER_W   = 4;      // step counter for 16 steps
    localparam int QUO_W    = 16;     // tangent quotient bits
    localparam int FRAC_SHIFT = 14;   // wheel fraction bits
    localparam int DIV_W    = XY_W - 1 + QUO_W - 1;
    localparam int PROD_W   = 2 * DATA_W + 1;

    // angle constants, 12 fraction bits
    localparam logic signed [ANG_W-1:0] ANG_PI      = 18'sd12868;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 18'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 18'sd6434;

    // CORDIC constants
    localparam logic signed [Z_W-1:0]  QUARTER_PI_Q16 = 20'sd51472;
    localparam logic signed [XY_W-1:0] CORDIC_INIT_X  = 27'sd16777216;
    localparam logic [ITER_W-1:0]      ITER_LAST      = 4'd15;

    // wheel factors, 14 fraction bits
    localparam logic signed [DATA_W-1:0] FULL_SCALE     = 16'sd16384;
    localparam logic signed [DATA_W-1:0] NEG_FULL_SCALE = -16'sd16384;
    localparam logic [QUO_W-1:0]         QUO_LIMIT      = 16'd16384;
    localparam logic signed [PROD_W-1:0] ROUND_HALF     = 33'sd8192;
    localparam logic signed [PROD_W-1:0] OUT_MAX        = 33'sd32767;
    localparam logic signed [PROD_W-1:0] OUT_MIN        = -33'sd32768;

    // wheel slots in result order
    localparam logic [1:0] WHEEL_TL = 2'd0;
    localparam logic [1:0] WHEEL_BL = 2'd1;
    localparam logic [1:0] WHEEL_TR = 2'd2;
    localparam logic [1:0] WHEEL_BR = 2'd3;

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,   // 0 .. pi/2
        QUAD_SECOND = 2'd1,   // above pi/2
        QUAD_THIRD  = 2'd2,   // -pi/2 .. 0
        QUAD_FOURTH = 2'd3    // below -pi/2
    } quad_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] heading;
        logic signed [DATA_W-1:0] bearing;
        logic signed [DATA_W-1:0] speed;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] wheel_top_left;
        logic signed [DATA_W-1:0] wheel_bottom_left;
        logic signed [DATA_W-1:0] wheel_top_right;
        logic signed [DATA_W-1:0] wheel_bottom_right;
    } out_item_t;

    // atan(2^-i), 16 fraction bits, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30385;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // factor of one wheel for a quadrant and tangent t
    function automatic logic signed [DATA_W-1:0] wheel_factor(
        input quad_t                    q,
        input logic [1:0]               k,
        input logic signed [DATA_W-1:0] t
    );
        logic signed [DATA_W-1:0] nt;
        logic signed [DATA_W-1:0] r;
        nt = -t;
        case (q)
            QUAD_FIRST:
            begin
                case (k)
                    WHEEL_TL: r = NEG_FULL_SCALE;
                    WHEEL_BL: r = t;
                    WHEEL_TR: r = nt;
                    default:  r = FULL_SCALE;
                endcase
            end
            QUAD_SECOND:
            begin
                case (k)
                    WHEEL_TL: r = t;
                    WHEEL_BL: r = FULL_SCALE;
                    WHEEL_TR: r = NEG_FULL_SCALE;
                    default:  r = nt;
                endcase
            end
            QUAD_THIRD:
            begin
                case (k)
                    WHEEL_TL: r = nt;
                    WHEEL_BL: r = NEG_FULL_SCALE;
                    WHEEL_TR: r = FULL_SCALE;
                    default:  r = t;
                endcase
            end
            default:
            begin
                case (k)
                    WHEEL_TL: r = FULL_SCALE;
                    WHEEL_BL: r = t;
                    WHEEL_TR: r = nt;
                    default:  r = NEG_FULL_SCALE;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/owdm_stream_if.sv =====
// Valid/ready stream channel carrying one item per transfer.
// The item type is set by the instantiating level; no package needed.
interface owdm_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/omni_wheel_drive_mixer.sv =====
// Four-wheel omni drive mixer: heading, bearing and speed in, four wheel drive values out.
// Depends on owdm_pkg and owdm_stream_if.
//
// One item is worked on at a time. After a transfer in, the heading and then the relative
// direction are wrapped into [-pi, pi] by one 2*pi step per cycle on a shared adder, a
// CORDIC unit runs 16 rotation steps, a set-up step prepares the divide, a restoring
// divider yields the tangent, and a single multiplier scales the four wheels in turn. The
// result is then loaded into the output register and the block is ready again in the cycle
// after that load. The output register holds a finished result while the next item is taken
// in; a new result waits in the wheel registers only if the previous one has not been taken.
module omni_wheel_drive_mixer
    import owdm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    owdm_stream_if.sink   in_ch,
    owdm_stream_if.source out_ch
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_WRAP_H = 8'b0000_0010,
        S_WRAP_D = 8'b0000_0100,
        S_ROT    = 8'b0000_1000,
        S_PREP   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_SCALE  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic signed [ANG_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_W-1:0] bearing_reg, bearing_next;
    logic signed [DATA_W-1:0] speed_reg, speed_next;
    quad_t                    quad_reg, quad_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         dsh_reg, dsh_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic                     ysign_reg, ysign_next;
    logic signed [DATA_W-1:0] t_reg, t_next;
    logic signed [DATA_W-1:0] wheel_reg [4];
    logic signed [DATA_W-1:0] wheel_next [4];
    out_item_t                out_data_reg, out_data_next;

    // shared wrap adder
    logic                    acc_gt, acc_lt;
    logic signed [ANG_W-1:0] wrap_sum;

    // quadrant selection
    logic signed [ANG_W-1:0]   a_wide;
    logic [ANG_A_W-1:0]        a_sel;
    quad_t                     quad_sel;
    logic signed [Z_W-1:0]     z_init;

    // CORDIC step
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;

    // divide set-up and step
    logic [XY_W-1:0]   abs_y;
    logic signed [XY_W-1:0] x_half;
    logic              x_nonpos;
    logic              div_ge;
    logic [QUO_W-1:0]  q_full, q_clamp;

    // wheel scaling
    logic signed [DATA_W-1:0] factor;
    logic signed [PROD_W-1:0] prod, rounded;
    logic signed [DATA_W-1:0] wheel_sat;

    logic in_fire, out_fire, out_load;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_fire     = out_valid_reg && out_ch.ready;
    assign out_load     = (state_reg == S_FINISH) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // wrap step: one 2*pi move towards [-pi, pi]
    assign acc_gt   = acc_reg > ANG_PI;
    assign acc_lt   = acc_reg < -ANG_PI;
    assign wrap_sum = acc_gt ? (acc_reg - ANG_TWO_PI) : (acc_reg + ANG_TWO_PI);

    // quadrant and in-quadrant angle of the wrapped direction
    always_comb
    begin
        if (!acc_reg[ANG_W-1] && acc_reg <= ANG_HALF_PI)
        begin
            quad_sel = QUAD_FIRST;
            a_wide   = acc_reg;
        end
        else if (acc_reg > ANG_HALF_PI)
        begin
            quad_sel = QUAD_SECOND;
            a_wide   = acc_reg - ANG_HALF_PI;
        end
        else if (acc_reg >= -ANG_HALF_PI)
        begin
            quad_sel = QUAD_THIRD;
            a_wide   = acc_reg + ANG_HALF_PI;
        end
        else
        begin
            quad_sel = QUAD_FOURTH;
            a_wide   = -acc_reg - ANG_HALF_PI;
        end
    end

    assign a_sel  = a_wide[ANG_A_W-1:0];
    assign z_init = $signed({{(Z_W-ANG_A_W-4){1'b0}}, a_sel, 4'b0000}) - QUARTER_PI_Q16;

    // CORDIC shifts, floor
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = atan_q16(iter_reg);

    // divide operands
    assign abs_y    = y_reg[XY_W-1] ? XY_W'(-y_reg) : XY_W'(y_reg);
    assign x_half   = x_reg >>> 1;
    assign x_nonpos = x_reg[XY_W-1] || (x_reg == '0);

    assign div_ge  = rem_reg >= dsh_reg;
    assign q_full  = {quo_reg[QUO_W-2:0], div_ge};
    assign q_clamp = (q_full > QUO_LIMIT) ? QUO_LIMIT : q_full;

    // wheel scale, round half up, saturate
    assign factor  = wheel_factor(quad_reg, iter_reg[1:0], t_reg);
    assign prod    = PROD_W'(speed_reg) * PROD_W'(factor);
    assign rounded = (prod + ROUND_HALF) >>> FRAC_SHIFT;

    always_comb
    begin
        if (rounded > OUT_MAX)
            wheel_sat = OUT_MAX[DATA_W-1:0];
        else if (rounded < OUT_MIN)
            wheel_sat = OUT_MIN[DATA_W-1:0];
        else
            wheel_sat = rounded[DATA_W-1:0];
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        bearing_next   = bearing_reg;
        speed_next     = speed_reg;
        quad_next      = quad_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        iter_next      = iter_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        ysign_next     = ysign_reg;
        t_next         = t_reg;
        wheel_next     = wheel_reg;
        out_data_next  = out_data_reg;

        if (out_fire)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next     = ANG_W'(in_ch.data.heading);
                    bearing_next = in_ch.data.bearing;
                    speed_next   = in_ch.data.speed;
                    state_next   = S_WRAP_H;
                end
            end
            S_WRAP_H:
            begin
                if (acc_gt || acc_lt)
                    acc_next = wrap_sum;
                else
                begin
                    acc_next   = ANG_W'(bearing_reg) - acc_reg;
                    state_next = S_WRAP_D;
                end
            end
            S_WRAP_D:
            begin
                if (acc_gt || acc_lt)
                    acc_next = wrap_sum;
                else
                begin
                    quad_next  = quad_sel;
                    x_next     = CORDIC_INIT_X;
                    y_next     = '0;
                    z_next     = z_init;
                    iter_next  = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                iter_next  = '0;
                ysign_next = y_reg[XY_W-1];
                if (x_nonpos)
                begin
                    t_next     = y_reg[XY_W-1] ? NEG_FULL_SCALE : FULL_SCALE;
                    state_next = S_SCALE;
                end
                else
                begin
                    rem_next   = (DIV_W'(abs_y) << FRAC_SHIFT) + DIV_W'($unsigned(x_half));
                    dsh_next   = DIV_W'($unsigned(x_reg)) << (QUO_W - 1);
                    quo_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_ge)
                    rem_next = rem_reg - dsh_reg;
                dsh_next  = dsh_reg >> 1;
                quo_next  = q_full;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    t_next     = ysign_reg ? -$signed(q_clamp) : $signed(q_clamp);
                    iter_next  = '0;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                wheel_next[iter_reg[1:0]] = wheel_sat;
                iter_next = iter_reg + 1'b1;
                if (iter_reg[1:0] == WHEEL_BR)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_data_next.wheel_top_left     = wheel_reg[WHEEL_TL];
                    out_data_next.wheel_bottom_left  = wheel_reg[WHEEL_BL];
                    out_data_next.wheel_top_right    = wheel_reg[WHEEL_TR];
                    out_data_next.wheel_bottom_right = wheel_reg[WHEEL_BR];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        bearing_reg  <= bearing_next;
        speed_reg    <= speed_next;
        quad_reg     <= quad_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        iter_reg     <= iter_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        ysign_reg    <= ysign_next;
        t_reg        <= t_next;
        wheel_reg    <= wheel_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // an input transfer always starts the heading wrap
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_WRAP_H)
        else $error("input transfer did not start the heading wrap");

    // tangent stays within full scale while wheels are scaled
    a_tan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |-> ((t_reg <= FULL_SCALE) && (t_reg >= NEG_FULL_SCALE)))
        else $error("tangent outside full scale");

    // a result appears only out of the finish step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finish step");
`endif

endmodule
